// ===== hw/rtl/hsv_to_rgb_rainbow_defines.svh =====
// assertion macros shared by the hsv to rgb rainbow rtl
`ifndef HSV_TO_RGB_RAINBOW_DEFINES_SVH
`define HSV_TO_RGB_RAINBOW_DEFINES_SVH

// property that must hold in the same cycle as its trigger
`define HSV_RBW_ASSERT_NOW(lbl, trig, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (expr)) \
        else $error(msg);

// property that must hold in the cycle after its trigger
`define HSV_RBW_ASSERT_NEXT(lbl, trig, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (expr)) \
        else $error(msg);

`endif

// ===== hw/rtl/hsv_rbw_pkg.sv =====
// shared types, constants and scaling functions for the rainbow hsv to rgb converter
package hsv_rbw_pkg;

    localparam logic [7:0] THIRD_K = 8'(256 / 3);
    localparam logic [7:0] TWOTH_K = 8'((256 * 2) / 3);
    localparam logic [7:0] FULL_K  = 8'd255;

    typedef enum logic [1:0] {
        REG_YELLOW_MODERATE = 2'd0,
        REG_YELLOW_STRONG   = 2'd1,
        REG_GREEN_HALVE     = 2'd2,
        REG_GREEN_SCALE     = 2'd3
    } hsv_rbw_reg_t;

    typedef enum logic [2:0] {
        SECT_RED_ORANGE    = 3'd0,
        SECT_ORANGE_YELLOW = 3'd1,
        SECT_YELLOW_GREEN  = 3'd2,
        SECT_GREEN_AQUA    = 3'd3,
        SECT_AQUA_BLUE     = 3'd4,
        SECT_BLUE_PURPLE   = 3'd5,
        SECT_PURPLE_PINK   = 3'd6,
        SECT_PINK_RED      = 3'd7
    } hsv_rbw_sect_t;

    typedef struct packed {
        logic       yellow_moderate;
        logic       yellow_strong;
        logic       green_halve;
        logic [7:0] green_scale;
    } hsv_rbw_cfg_t;

    // pixel as it travels down the pipe
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] sat;
        logic [7:0] val;
        logic [7:0] d;
        logic [7:0] v;
    } hsv_rbw_px_t;

    // (x * (k + 1)) >> 8
    function automatic logic [7:0] sc8(input logic [7:0] x, input logic [7:0] k);
        logic [15:0] p;
        p = 16'(x) * (16'(k) + 16'd1);
        return p[15:8];
    endfunction

    // video scale: never rounds a nonzero product down to zero
    function automatic logic [7:0] scv(input logic [7:0] x, input logic [7:0] k);
        logic [15:0] p;
        p = 16'(x) * 16'(k);
        return p[15:8] + 8'((x != 8'd0) && (k != 8'd0));
    endfunction

endpackage

// ===== hw/rtl/hsv_rbw_regs.sv =====
// apb configuration registers
module hsv_rbw_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output hsv_rbw_pkg::hsv_rbw_cfg_t cfg
);
    import hsv_rbw_pkg::*;

    hsv_rbw_cfg_t cfg_reg;
    hsv_rbw_reg_t idx;
    logic         wr_en;

    assign idx    = hsv_rbw_reg_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.yellow_moderate <= 1'b1;
            cfg_reg.yellow_strong   <= 1'b0;
            cfg_reg.green_halve     <= 1'b0;
            cfg_reg.green_scale     <= 8'd0;
        end else if (wr_en) begin
            unique case (idx)
                REG_YELLOW_MODERATE: cfg_reg.yellow_moderate <= pwdata[0];
                REG_YELLOW_STRONG:   cfg_reg.yellow_strong   <= pwdata[0];
                REG_GREEN_HALVE:     cfg_reg.green_halve     <= pwdata[0];
                REG_GREEN_SCALE:     cfg_reg.green_scale     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        unique case (idx)
            REG_YELLOW_MODERATE: prdata = 32'(cfg_reg.yellow_moderate);
            REG_YELLOW_STRONG:   prdata = 32'(cfg_reg.yellow_strong);
            REG_GREEN_HALVE:     prdata = 32'(cfg_reg.green_halve);
            REG_GREEN_SCALE:     prdata = 32'(cfg_reg.green_scale);
            default:             prdata = 32'd0;
        endcase
    end

endmodule

// ===== hw/rtl/hsv_rbw_hue.sv =====
// stage 1: hue section mapping with yellow boost
module hsv_rbw_hue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  hsv_rbw_pkg::hsv_rbw_cfg_t cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                hue,
    input  logic [7:0]                sat,
    input  logic [7:0]                val,
    output logic                      out_valid,
    input  logic                      out_ready,
    output hsv_rbw_pkg::hsv_rbw_px_t  out_px
);
    import hsv_rbw_pkg::*;

    logic        valid_reg;
    hsv_rbw_px_t px_reg;
    hsv_rbw_px_t px_next;
    logic [7:0]  o8;
    logic [7:0]  third;
    logic [7:0]  twoth;

    assign o8    = {hue[4:0], 3'b000};
    assign third = sc8(o8, THIRD_K);
    assign twoth = sc8(o8, TWOTH_K);

    always_comb begin
        px_next     = '0;
        px_next.sat = sat;
        px_next.val = val;
        case (hsv_rbw_sect_t'(hue[7:5]))
            SECT_RED_ORANGE: begin
                px_next.r = FULL_K - third;
                px_next.g = third;
            end
            SECT_ORANGE_YELLOW: begin
                if (cfg.yellow_moderate) begin
                    px_next.r = 8'd171;
                    px_next.g = 8'd85 + third;
                end
                if (cfg.yellow_strong) begin
                    px_next.r = 8'd170 + third;
                    px_next.g = 8'd85 + twoth;
                end
            end
            SECT_YELLOW_GREEN: begin
                if (cfg.yellow_moderate) begin
                    px_next.r = 8'd171 - twoth;
                    px_next.g = 8'd170 + third;
                end
                if (cfg.yellow_strong) begin
                    px_next.r = FULL_K - o8;
                    px_next.g = FULL_K;
                end
            end
            SECT_GREEN_AQUA: begin
                px_next.g = FULL_K - third;
                px_next.b = third;
            end
            SECT_AQUA_BLUE: begin
                px_next.g = 8'd171 - twoth;
                px_next.b = 8'd85 + twoth;
            end
            SECT_BLUE_PURPLE: begin
                px_next.r = third;
                px_next.b = FULL_K - third;
            end
            SECT_PURPLE_PINK: begin
                px_next.r = 8'd85 + third;
                px_next.b = 8'd171 - third;
            end
            SECT_PINK_RED: begin
                px_next.r = 8'd170 + third;
                px_next.b = 8'd85 - third;
            end
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_px    = px_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            px_reg <= px_next;
        end
    end

endmodule

// ===== hw/rtl/hsv_rbw_green.sv =====
// stage 2: green shaping plus the squared desaturation floor and value factor
module hsv_rbw_green (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  hsv_rbw_pkg::hsv_rbw_cfg_t cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  hsv_rbw_pkg::hsv_rbw_px_t  in_px,
    output logic                      out_valid,
    input  logic                      out_ready,
    output hsv_rbw_pkg::hsv_rbw_px_t  out_px
);
    import hsv_rbw_pkg::*;

    logic        valid_reg;
    hsv_rbw_px_t px_reg;
    hsv_rbw_px_t px_next;
    logic [7:0]  g_half;

    assign g_half = cfg.green_halve ? {1'b0, in_px.g[7:1]} : in_px.g;

    always_comb begin
        px_next   = in_px;
        px_next.g = (cfg.green_scale != 8'd0) ? scv(g_half, cfg.green_scale) : g_half;
        // 255 - sat is the bitwise complement
        px_next.d = scv(~in_px.sat, ~in_px.sat);
        px_next.v = scv(in_px.val, in_px.val);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_px    = px_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            px_reg <= px_next;
        end
    end

endmodule

// ===== hw/rtl/hsv_rbw_desat.sv =====
// stage 3: desaturation toward white
module hsv_rbw_desat (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  hsv_rbw_pkg::hsv_rbw_px_t in_px,
    output logic                     out_valid,
    input  logic                     out_ready,
    output hsv_rbw_pkg::hsv_rbw_px_t out_px
);
    import hsv_rbw_pkg::*;

    logic        valid_reg;
    hsv_rbw_px_t px_reg;
    hsv_rbw_px_t px_next;
    logic [7:0]  s;

    function automatic logic [7:0] desat_chan(input logic [7:0] c, input logic [7:0] k,
                                              input logic [7:0] d);
        logic [7:0] c1;
        c1 = (c != 8'd0) ? sc8(c, k) + 8'd1 : 8'd0;
        return c1 + d;
    endfunction

    assign s = ~in_px.d;

    always_comb begin
        px_next = in_px;
        if (in_px.sat == 8'd0) begin
            px_next.r = FULL_K;
            px_next.g = FULL_K;
            px_next.b = FULL_K;
        end else if (in_px.sat != FULL_K) begin
            px_next.r = desat_chan(in_px.r, s, in_px.d);
            px_next.g = desat_chan(in_px.g, s, in_px.d);
            px_next.b = desat_chan(in_px.b, s, in_px.d);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_px    = px_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            px_reg <= px_next;
        end
    end

endmodule

// ===== hw/rtl/hsv_rbw_dim.sv =====
// stage 4: value scaling, also the output register
module hsv_rbw_dim (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  hsv_rbw_pkg::hsv_rbw_px_t in_px,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [7:0]               red,
    output logic [7:0]               green,
    output logic [7:0]               blue
);
    import hsv_rbw_pkg::*;

    logic       valid_reg;
    logic [7:0] r_reg;
    logic [7:0] g_reg;
    logic [7:0] b_reg;
    logic [7:0] r_next;
    logic [7:0] g_next;
    logic [7:0] b_next;

    function automatic logic [7:0] dim_chan(input logic [7:0] c, input logic [7:0] v);
        return (c != 8'd0) ? sc8(c, v) + 8'd1 : 8'd0;
    endfunction

    always_comb begin
        r_next = in_px.r;
        g_next = in_px.g;
        b_next = in_px.b;
        if (in_px.val != FULL_K) begin
            if (in_px.v == 8'd0) begin
                r_next = 8'd0;
                g_next = 8'd0;
                b_next = 8'd0;
            end else begin
                r_next = dim_chan(in_px.r, in_px.v);
                g_next = dim_chan(in_px.g, in_px.v);
                b_next = dim_chan(in_px.b, in_px.v);
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign red       = r_reg;
    assign green     = g_reg;
    assign blue      = b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            r_reg <= r_next;
            g_reg <= g_next;
            b_reg <= b_next;
        end
    end

endmodule

// ===== hw/rtl/hsv_to_rgb_rainbow.sv =====
// Rainbow hsv to rgb converter: takes one pixel per clock and returns one pixel per clock
// while m_ready is high, through four register stages (hue section mapping, green shaping
// with the saturation and value squaring multipliers, desaturation, value scaling). The
// fourth stage is the output register.
// Each stage holds its own transaction and passes it on as soon as the next stage has room,
// so empty slots close up under output backpressure and s_ready drops only when all four
// stages are full and m_ready is low. Configuration is read live by the stages and should
// be written only while no transaction is in flight.
`include "hsv_to_rgb_rainbow_defines.svh"

module hsv_to_rgb_rainbow (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_hue,
    input  logic [7:0]  s_sat,
    input  logic [7:0]  s_val,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue
);
    import hsv_rbw_pkg::*;

    hsv_rbw_cfg_t cfg;
    hsv_rbw_px_t  px1;
    hsv_rbw_px_t  px2;
    hsv_rbw_px_t  px3;
    logic         v1;
    logic         v2;
    logic         v3;
    logic         r2;
    logic         r3;
    logic         r4;

    hsv_rbw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hsv_rbw_hue u_hue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .hue       (s_hue),
        .sat       (s_sat),
        .val       (s_val),
        .out_valid (v1),
        .out_ready (r2),
        .out_px    (px1)
    );

    hsv_rbw_green u_green (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (v1),
        .in_ready  (r2),
        .in_px     (px1),
        .out_valid (v2),
        .out_ready (r3),
        .out_px    (px2)
    );

    hsv_rbw_desat u_desat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2),
        .in_ready  (r3),
        .in_px     (px2),
        .out_valid (v3),
        .out_ready (r4),
        .out_px    (px3)
    );

    hsv_rbw_dim u_dim (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v3),
        .in_ready  (r4),
        .in_px     (px3),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .red       (m_red),
        .green     (m_green),
        .blue      (m_blue)
    );

    // input backpressure only when every stage is occupied and the output is stalled
    `HSV_RBW_ASSERT_NOW(a_full_stall, !s_ready, v1 && v2 && v3 && m_valid && !m_ready,
                        "s_ready low with a free stage")
    // an accepted transaction always lands in the first stage
    `HSV_RBW_ASSERT_NEXT(a_accept_lands, s_valid && s_ready, v1,
                         "accepted transaction lost at stage 1")
    // a new result only appears if stage 3 held a transaction
    `HSV_RBW_ASSERT_NOW(a_out_source, $rose(m_valid), $past(v3),
                        "result without a transaction in stage 3")

endmodule
